### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PCS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sequencer assertion failed");

// Clocked assertion that also holds across reset.
`define PCS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("sequencer reset assertion failed");

`endif

### rtl/core/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Types, constants and helpers of the precharge contactor sequencer.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int CNT_W     = 8;
    localparam int CFG_W     = 8;
    localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int STATUS_W  = 8;
    localparam int DRIVE_W   = 12;
    localparam int NUM_CH    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [CNT_W-1:0]    CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [STATUS_W-1:0] READY_CODE  = 8'h20;
    localparam logic [CFG_W-1:0]    PRE_TICKS_RST = 8'd30;
    localparam logic [CFG_W-1:0]    REL_AFTER_RST = 8'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_PRECHARGE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_AFTER   = 2'd1;

    // Drive vector positions of the channel contactors.
    localparam int PRE_BIT  [NUM_CH] = '{0, 2, 5, 7};
    localparam int MAIN_BIT [NUM_CH] = '{1, 3, 6, 8};
    localparam int AUX0_BIT  = 4;
    localparam int AUX1_BIT  = 9;
    localparam int PUMP0_BIT = 10;
    localparam int PUMP1_BIT = 11;

    typedef struct packed {
        logic             step;
        logic             close;
        logic [CNT_W-1:0] thr;
        logic [CNT_W-1:0] lim;
    } t_chan_ctrl;

    typedef struct packed {
        logic pre;
        logic main;
    } t_chan_stat;

    typedef struct packed {
        logic [DRIVE_W-1:0] contactor_drive;
        logic               peer_close_command;
        logic               acm_group_a_run;
        logic               acm_group_b_run;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

### rtl/core/pcs_if.sv
// ----------------------------------------------------------------------------
// Sequencer channel interfaces
// Tick input, result output and register write channels.
// ----------------------------------------------------------------------------
interface pcs_in_if
    import pcs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                is_master;
    logic [STATUS_W-1:0] pack1_hv_status;
    logic [STATUS_W-1:0] pack2_hv_status;
    logic                slave_close_request;

    modport source (output valid, is_master, pack1_hv_status, pack2_hv_status,
                    slave_close_request, input ready);
    modport sink   (input valid, is_master, pack1_hv_status, pack2_hv_status,
                    slave_close_request, output ready);
endinterface

interface pcs_out_if
    import pcs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DRIVE_W-1:0] contactor_drive;
    logic               peer_close_command;
    logic               acm_group_a_run;
    logic               acm_group_b_run;

    modport source (output valid, contactor_drive, peer_close_command,
                    acm_group_a_run, acm_group_b_run, input ready);
    modport sink   (input valid, contactor_drive, peer_close_command,
                    acm_group_a_run, acm_group_b_run, output ready);
endinterface

interface pcs_cfg_if
    import pcs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/pcs_channel.sv
// ----------------------------------------------------------------------------
// pcs_channel
// One precharge channel: precharge and main contactor with their counters.
// ----------------------------------------------------------------------------
module pcs_channel
    import pcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chan_ctrl i_ctrl,
    output t_chan_stat o_stat
);

    logic             r_pre, r_main;
    logic [CNT_W-1:0] r_pc, r_rc;
    logic             n_pre, n_main;
    logic [CNT_W-1:0] n_pc, n_rc;

    always_comb begin
        n_pre  = r_pre;
        n_main = r_main;
        n_pc   = r_pc;
        n_rc   = r_rc;
        if (i_ctrl.close) begin
            if (!r_main) begin
                if (r_pc < i_ctrl.thr) begin
                    if (r_pc == '0) begin
                        n_pre = 1'b1;
                    end
                    n_pc = sat_inc(r_pc);
                end
                if (n_pc >= i_ctrl.thr) begin
                    n_main = 1'b1;
                end
            end
            // The release counter runs while the main contactor is closed and
            // restarts each time it passes the limit.
            if (n_main) begin
                n_rc = sat_inc(r_rc);
                if (r_rc > i_ctrl.lim) begin
                    n_pre = 1'b0;
                    n_pc  = '0;
                    n_rc  = '0;
                end
            end
        end else begin
            // Opening keeps the release count.
            n_pre  = 1'b0;
            n_main = 1'b0;
            n_pc   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre  <= 1'b0;
            r_main <= 1'b0;
            r_pc   <= '0;
            r_rc   <= '0;
        end else if (i_ctrl.step) begin
            r_pre  <= n_pre;
            r_main <= n_main;
            r_pc   <= n_pc;
            r_rc   <= n_rc;
        end
    end

    assign o_stat.pre  = n_pre;
    assign o_stat.main = n_main;

endmodule

### rtl/core/precharge_contactor_sequencer_top.sv
// ----------------------------------------------------------------------------
// precharge_contactor_sequencer_top
// Master/slave close decision and four precharge channels for the HV packs.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                          Beat when
//  i_in     in   is_master, pack1/pack2_hv_status, close request  valid & ready
//  o_out    out  contactor_drive, peer_close_command, acm runs    valid & ready
//  i_cfg    in   index, data (0: precharge_ticks, 1: release_after) valid (ready high)
//
//  One tick beat per cycle while i_in.ready is high; its result is registered in the result queue on acceptance.
//  The state update is one pass of compare/increment logic per channel.
//  A two-entry result queue lets input beats keep flowing while o_out stalls;
//  i_in.ready drops only when both entries are full.
//  Synchronous reset opens all contactors and clears counters and holds.
// ----------------------------------------------------------------------------
module precharge_contactor_sequencer_top
    import pcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcs_in_if.sink      i_in,
    pcs_out_if.source   o_out,
    pcs_cfg_if.sink     i_cfg
);

    logic [CFG_W-1:0] r_pre_ticks, r_rel_after;
    logic             r_peer;
    logic [1:0]       r_acm;
    logic             n_peer;
    logic [1:0]       n_acm;

    logic             accept, pop, close_now, p2_ready;
    logic [CMP_W-1:0] thr_wide, lim_wide;
    logic [CNT_W-1:0] thr, lim;
    t_chan_ctrl       chan_ctrl;
    t_chan_stat       chan_stat [NUM_CH];
    logic [DRIVE_W-1:0] drive_next;
    t_result          result;

    t_result                r_slot [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_ticks <= PRE_TICKS_RST;
            r_rel_after <= REL_AFTER_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PRECHARGE_TICKS: r_pre_ticks <= i_cfg.data;
                CFG_RELEASE_AFTER:   r_rel_after <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Thresholds clipped to the counter range.
    always_comb begin
        thr_wide = CMP_W'(r_pre_ticks);
        lim_wide = CMP_W'(r_rel_after);
        if (thr_wide > CMP_W'(CNT_MAX)) begin
            thr_wide = CMP_W'(CNT_MAX);
        end
        if (lim_wide > CMP_W'(CNT_MAX) - 1'b1) begin
            lim_wide = CMP_W'(CNT_MAX) - 1'b1;
        end
    end

    assign thr = thr_wide[CNT_W-1:0];
    assign lim = lim_wide[CNT_W-1:0];

    // Close decision and master-side commands
    assign accept    = i_in.valid && i_in.ready;
    assign p2_ready  = (i_in.pack2_hv_status == READY_CODE);
    assign close_now = i_in.is_master ? (i_in.pack1_hv_status == READY_CODE)
                                      : i_in.slave_close_request;

    always_comb begin
        n_peer = r_peer;
        n_acm  = r_acm;
        if (i_in.is_master) begin
            n_peer = p2_ready;
            n_acm  = {p2_ready, close_now};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer <= 1'b0;
            r_acm  <= '0;
        end else if (accept) begin
            r_peer <= n_peer;
            r_acm  <= n_acm;
        end
    end

    assign chan_ctrl.step  = accept;
    assign chan_ctrl.close = close_now;
    assign chan_ctrl.thr   = thr;
    assign chan_ctrl.lim   = lim;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
        pcs_channel u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (chan_ctrl),
            .o_stat  (chan_stat[c])
        );
    end

    always_comb begin
        drive_next = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            drive_next[PRE_BIT[c]]  = chan_stat[c].pre;
            drive_next[MAIN_BIT[c]] = chan_stat[c].main;
        end
        drive_next[AUX0_BIT]  = close_now;
        drive_next[AUX1_BIT]  = close_now;
        drive_next[PUMP0_BIT] = close_now;
        drive_next[PUMP1_BIT] = close_now;
    end

    assign result.contactor_drive    = drive_next;
    assign result.peer_close_command = n_peer;
    assign result.acm_group_a_run    = n_acm[0];
    assign result.acm_group_b_run    = n_acm[1];

    // Result queue
    assign pop        = o_out.valid && o_out.ready;
    assign i_in.ready = (r_count != FIFO_CNT_W'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[r_wr_ptr] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (accept && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !accept) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_out.valid              = (r_count != '0);
    assign o_out.contactor_drive    = r_slot[r_rd_ptr].contactor_drive;
    assign o_out.peer_close_command = r_slot[r_rd_ptr].peer_close_command;
    assign o_out.acm_group_a_run    = r_slot[r_rd_ptr].acm_group_a_run;
    assign o_out.acm_group_b_run    = r_slot[r_rd_ptr].acm_group_b_run;

endmodule

### rtl/core/pcs_checker.sv
// ----------------------------------------------------------------------------
// pcs_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcs_checker
    import pcs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [DRIVE_W-1:0] i_drive,
    input logic               i_peer,
    input logic               i_acm_b
);

    // A stalled result beat keeps its drive pattern.
    `PCS_ASSERT(a_out_hold, i_clk, i_rst_n,
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_drive)))

    // Any closed contactor implies the aux and pump contactors are closed.
    `PCS_ASSERT(a_aux_with_close, i_clk, i_rst_n,
        (i_out_valid && (i_drive != '0)) |->
        (i_drive[AUX0_BIT] && i_drive[AUX1_BIT] &&
         i_drive[PUMP0_BIT] && i_drive[PUMP1_BIT]))

    // The peer command and group B run flag come from the same pack status.
    `PCS_ASSERT(a_peer_matches_b, i_clk, i_rst_n,
        i_out_valid |-> (i_peer == i_acm_b))

    // Nothing is offered right after reset.
    `PCS_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !i_out_valid)

endmodule

bind precharge_contactor_sequencer_top pcs_checker u_pcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_drive     (o_out.contactor_drive),
    .i_peer      (o_out.peer_close_command),
    .i_acm_b     (o_out.acm_group_b_run)
);

### sim/precharge_contactor_sequencer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// precharge_contactor_sequencer_checker
// Watches the tick, result and register write channels of the sequencer.
// It keeps its own copy of the contactor state, works out the result of
// every accepted tick and compares each result beat field by field.
// ----------------------------------------------------------------------------
module precharge_contactor_sequencer_checker
    import pcs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pcs_in_if    i_tick,
    pcs_out_if   i_result,
    pcs_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending
);

    logic [CFG_W-1:0]   ticks_cfg;
    logic [CFG_W-1:0]   release_cfg;
    logic [DRIVE_W-1:0] drive_q;
    logic [CNT_W-1:0]   pre_cnt [NUM_CH];
    logic [CNT_W-1:0]   rel_cnt [NUM_CH];
    logic               peer_hold;
    logic [1:0]         acm_hold;

    t_result            drive_expected_q [$];
    int                 err_cnt = 0;

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return v + {{(CNT_W-1){1'b0}}, (v != CNT_MAX)};
    endfunction

    // Advances the contactor state by one tick and returns the outputs after it.
    function automatic t_result predict_tick(input logic             master,
                                             input logic [STATUS_W-1:0] p1,
                                             input logic [STATUS_W-1:0] p2,
                                             input logic             req);
        logic             close_now;
        logic [CNT_W-1:0] thr;
        logic [CNT_W-1:0] lim;
        logic [CNT_W-1:0] old;
        t_result          r;

        if (master) begin
            close_now = (p1 == READY_CODE);
            peer_hold = (p2 == READY_CODE);
            acm_hold  = {p2 == READY_CODE, close_now};
        end else begin
            close_now = req;
        end

        if (close_now) begin
            thr = (ticks_cfg > CNT_MAX) ? CNT_MAX : CNT_W'(ticks_cfg);
            lim = (release_cfg > CNT_MAX - 1) ? CNT_MAX - 1'b1 : CNT_W'(release_cfg);
            drive_q[AUX0_BIT]  = 1'b1;
            drive_q[AUX1_BIT]  = 1'b1;
            drive_q[PUMP0_BIT] = 1'b1;
            drive_q[PUMP1_BIT] = 1'b1;
            for (int c = 0; c < NUM_CH; c++) begin
                if (!drive_q[MAIN_BIT[c]]) begin
                    if (pre_cnt[c] < thr) begin
                        if (pre_cnt[c] == '0)
                            drive_q[PRE_BIT[c]] = 1'b1;
                        pre_cnt[c] = count_up(pre_cnt[c]);
                    end
                    if (pre_cnt[c] >= thr)
                        drive_q[MAIN_BIT[c]] = 1'b1;
                end
            end
            // The release counter restarts each time it passes the limit, and
            // it keeps running for as long as the main contactor stays closed.
            for (int c = 0; c < NUM_CH; c++) begin
                if (drive_q[MAIN_BIT[c]]) begin
                    old        = rel_cnt[c];
                    rel_cnt[c] = count_up(old);
                    if (old > lim) begin
                        drive_q[PRE_BIT[c]] = 1'b0;
                        pre_cnt[c]          = '0;
                        rel_cnt[c]          = '0;
                    end
                end
            end
        end else begin
            // Release counters are left as they are on an open tick.
            drive_q = '0;
            for (int c = 0; c < NUM_CH; c++)
                pre_cnt[c] = '0;
        end

        r.contactor_drive    = drive_q;
        r.peer_close_command = peer_hold;
        r.acm_group_a_run    = acm_hold[0];
        r.acm_group_b_run    = acm_hold[1];
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;

        if (!i_rst_n) begin
            ticks_cfg   = PRE_TICKS_RST;
            release_cfg = REL_AFTER_RST;
            drive_q     = '0;
            for (int c = 0; c < NUM_CH; c++) begin
                pre_cnt[c] = '0;
                rel_cnt[c] = '0;
            end
            peer_hold = 1'b0;
            acm_hold  = 2'b00;
            drive_expected_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_PRECHARGE_TICKS: ticks_cfg   = i_cfg.data;
                    CFG_RELEASE_AFTER:   release_cfg = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_tick.valid && i_tick.ready)
                drive_expected_q.push_back(predict_tick(i_tick.is_master,
                                                        i_tick.pack1_hv_status,
                                                        i_tick.pack2_hv_status,
                                                        i_tick.slave_close_request));
            if (i_result.valid && i_result.ready) begin
                got.contactor_drive    = i_result.contactor_drive;
                got.peer_close_command = i_result.peer_close_command;
                got.acm_group_a_run    = i_result.acm_group_a_run;
                got.acm_group_b_run    = i_result.acm_group_b_run;
                if (drive_expected_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, actual 0x%0h",
                             $time, got);
                    err_cnt++;
                end else begin
                    want = drive_expected_q.pop_front();
                    check_field("contactor_drive", int'(want.contactor_drive),
                                int'(got.contactor_drive));
                    check_field("peer_close_command", int'(want.peer_close_command),
                                int'(got.peer_close_command));
                    check_field("acm_group_a_run", int'(want.acm_group_a_run),
                                int'(got.acm_group_a_run));
                    check_field("acm_group_b_run", int'(want.acm_group_b_run),
                                int'(got.acm_group_b_run));
                end
            end
        end
        o_errors  <= err_cnt;
        o_pending <= drive_expected_q.size();
    end

endmodule

### sim/precharge_contactor_sequencer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// precharge_contactor_sequencer_top_tb
// Drives control ticks and register writes into the sequencer, with random
// gaps and output stalls, and leaves the checking to the checker module.
// A short directed run covers both roles and the corner settings; random
// phases then run long close sequences under several precharge and release
// settings so that every channel goes through precharge, main and release.
// ----------------------------------------------------------------------------
module precharge_contactor_sequencer_top_tb;
    import pcs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic calm;
    int   errors;
    int   pending;

    pcs_in_if  tick_bus ();
    pcs_out_if result_bus ();
    pcs_cfg_if cfg_bus ();

    precharge_contactor_sequencer_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (tick_bus),
        .o_out   (result_bus),
        .i_cfg   (cfg_bus)
    );

    precharge_contactor_sequencer_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_tick    (tick_bus),
        .i_result  (result_bus),
        .i_cfg     (cfg_bus),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        result_bus.ready <= calm || ($urandom_range(99) >= 15);
    end

    task automatic send_tick(input logic master, input logic [STATUS_W-1:0] p1,
                             input logic [STATUS_W-1:0] p2, input logic req);
        if (!calm && $urandom_range(99) < 15) begin
            tick_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        tick_bus.valid               <= 1'b1;
        tick_bus.is_master           <= master;
        tick_bus.pack1_hv_status     <= p1;
        tick_bus.pack2_hv_status     <= p2;
        tick_bus.slave_close_request <= req;
        @(posedge clk);
        while (!tick_bus.ready) @(posedge clk);
    endtask

    // Random tick content that leads to the given close decision.
    task automatic decided_tick(input logic close_now);
        logic                master;
        logic [STATUS_W-1:0] p1;
        logic [STATUS_W-1:0] p2;

        master = 1'($urandom_range(1));
        p2     = ($urandom_range(3) == 0) ? READY_CODE : STATUS_W'($urandom_range(255));
        if (master) begin
            p1 = STATUS_W'($urandom_range(255));
            if (close_now)
                p1 = READY_CODE;
            else if (p1 == READY_CODE)
                p1 = p1 ^ 8'h01;
            send_tick(1'b1, p1, p2, 1'($urandom_range(1)));
        end else begin
            p1 = ($urandom_range(3) == 0) ? READY_CODE : STATUS_W'($urandom_range(255));
            send_tick(1'b0, p1, p2, close_now);
        end
    endtask

    // Lets every outstanding result drain with no tick on offer.
    task automatic drain;
        tick_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        drain();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly close runs long enough to finish precharge and pass the release
    // limit, broken by short runs, open runs and the odd random tick.
    task automatic run_phase(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] lim,
                             input int n_items);
        int sent;
        int run_len;

        write_reg(CFG_PRECHARGE_TICKS, thr);
        write_reg(CFG_RELEASE_AFTER, lim);
        write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, CFG_W'($urandom_range(255)));
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 20)
                run_len = $urandom_range(1, int'(thr) + 1);
            else
                run_len = int'(thr) + int'(lim) + 2 + $urandom_range(0, 40);
            for (int i = 0; i < run_len; i++) begin
                if ($urandom_range(99) < 3)
                    decided_tick(1'($urandom_range(1)));
                else
                    decided_tick(1'b1);
            end
            sent += run_len;
            run_len = $urandom_range(1, 5);
            for (int i = 0; i < run_len; i++)
                decided_tick(1'b0);
            sent += run_len;
        end
    endtask

    initial begin
        rst_n                        = 1'b0;
        calm                         = 1'b0;
        tick_bus.valid               = 1'b0;
        tick_bus.is_master           = 1'b0;
        tick_bus.pack1_hv_status     = '0;
        tick_bus.pack2_hv_status     = '0;
        tick_bus.slave_close_request = 1'b0;
        cfg_bus.valid                = 1'b0;
        cfg_bus.index                = CFG_PRECHARGE_TICKS;
        cfg_bus.data                 = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Both roles at the reset settings.
        send_tick(1'b1, READY_CODE, READY_CODE, 1'b0);
        send_tick(1'b1, 8'h00, 8'hFF, 1'b1);
        send_tick(1'b1, 8'hFF, READY_CODE, 1'b1);
        send_tick(1'b0, READY_CODE, READY_CODE, 1'b0);
        send_tick(1'b0, 8'hDF, 8'h00, 1'b1);

        // Zero precharge threshold with the smallest release limit.
        write_reg(CFG_PRECHARGE_TICKS, 8'd0);
        write_reg(CFG_RELEASE_AFTER, 8'd0);
        repeat (4) send_tick(1'b0, 8'h00, 8'h00, 1'b1);
        send_tick(1'b1, READY_CODE, 8'h21, 1'b0);

        // Writes to unused register indexes must change nothing.
        write_reg(CFG_SPARE_2, 8'hFF);
        write_reg(CFG_SPARE_3, 8'hAA);
        send_tick(1'b1, READY_CODE, 8'hDF, 1'b1);

        // A release limit above CNT_MAX - 1 is clipped.
        write_reg(CFG_PRECHARGE_TICKS, 8'd1);
        write_reg(CFG_RELEASE_AFTER, 8'd255);
        repeat (6) send_tick(1'b1, READY_CODE, READY_CODE, 1'b0);
        send_tick(1'b1, 8'h1F, 8'h1F, 1'b1);

        run_phase(8'd30, 8'd10, 220);
        run_phase(8'd1, 8'd0, 220);
        run_phase(8'd0, 8'd255, 260);
        calm <= 1'b1;
        run_phase(8'd255, 8'd254, 450);
        calm <= 1'b0;
        run_phase(8'd3, 8'd2, 170);
        run_phase(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(0, 30)), 130);

        drain();
        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
